// ===== design/fct_pkg.sv =====
// shared types, command codes and widths for the frustum containment test
package fct_pkg;

  localparam int PLANE_COUNT_DEF = 6;

  // plane value accumulator: three 64-bit products, three 63-bit extent terms, d scaled
  localparam int ACC_W = 67;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_BOX    = 2'd1;
  localparam logic [1:0] CMD_SPHERE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [1:0]  command;
    logic [2:0]  plane_index;
    logic [31:0] vec_x;
    logic [31:0] vec_y;
    logic [31:0] vec_z;
    logic [31:0] vec_w;
    logic [30:0] ext_x;
    logic [30:0] ext_y;
    logic [30:0] ext_z;
  } fct_item_t;

  typedef struct packed {
    logic valid;
    logic in_view;
  } fct_cull_t;

endpackage

// ===== design/fct_in_if.sv =====
// input channel: commands with plane or object operands
interface fct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  plane_index;
  logic [31:0] vec_x;
  logic [31:0] vec_y;
  logic [31:0] vec_z;
  logic [31:0] vec_w;
  logic [30:0] ext_x;
  logic [30:0] ext_y;
  logic [30:0] ext_z;

  modport source (
    output valid, command, plane_index, vec_x, vec_y, vec_z, vec_w, ext_x, ext_y, ext_z,
    input  ready
  );
  modport sink (
    input  valid, command, plane_index, vec_x, vec_y, vec_z, vec_w, ext_x, ext_y, ext_z,
    output ready
  );
endinterface

// ===== design/fct_out_if.sv =====
// result channel: one inside flag per test
interface fct_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ===== design/fct_cell.sv =====
// one plane cell: holds one plane, tests the passing object against it in three stages
module fct_cell
  import fct_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  fct_item_t item_i,
  output fct_item_t item_o,
  input  fct_cull_t cull_i,
  output fct_cull_t cull_o
);

  logic signed [31:0] a_r, b_r, c_r, d_r;
  fct_item_t          item_r;

  logic               is_test;
  logic               load_hit;
  logic [31:0]        abs_a, abs_b, abs_c;

  // stage 1: products
  logic               m_valid_r, m_box_r;
  logic signed [63:0] pa_r, pb_r, pc_r;
  logic signed [63:0] pa_nxt, pb_nxt, pc_nxt;
  logic [62:0]        ea_r, eb_r, ec_r;
  logic [62:0]        ea_nxt, eb_nxt, ec_nxt;
  logic signed [32:0] dw_r, dw_nxt;

  // stage 2: partial sums
  logic                    s_valid_r;
  logic signed [ACC_W-1:0] sp_r, sq_r, sp_nxt, sq_nxt;
  logic [ACC_W-1:0]        ext_sum;
  logic signed [ACC_W-1:0] dw_ext;

  // stage 3: sign of the plane value
  logic signed [ACC_W-1:0] total;
  fct_cull_t               cull_r, cull_nxt;

  always_comb begin
    unique case (item_i.command) inside
      CMD_BOX, CMD_SPHERE: is_test = 1'b1;
      CMD_LOAD, CMD_NONE:  is_test = 1'b0;
    endcase
  end

  assign load_hit = item_i.valid && (item_i.command == CMD_LOAD) &&
                    ({29'd0, item_i.plane_index} == 32'(CELL_ID));

  // magnitude of each coefficient picks the farthest corner along the normal
  assign abs_a = a_r[31] ? (~a_r + 32'd1) : a_r;
  assign abs_b = b_r[31] ? (~b_r + 32'd1) : b_r;
  assign abs_c = c_r[31] ? (~c_r + 32'd1) : c_r;

  assign pa_nxt = $signed(a_r) * $signed(item_i.vec_x);
  assign pb_nxt = $signed(b_r) * $signed(item_i.vec_y);
  assign pc_nxt = $signed(c_r) * $signed(item_i.vec_z);
  assign ea_nxt = abs_a * item_i.ext_x;
  assign eb_nxt = abs_b * item_i.ext_y;
  assign ec_nxt = abs_c * item_i.ext_z;

  // sphere folds the radius into d
  assign dw_nxt = (item_i.command == CMD_BOX) ? {d_r[31], d_r} :
                  ({d_r[31], d_r} + {item_i.vec_w[31], item_i.vec_w});

  assign ext_sum = ACC_W'(ea_r) + ACC_W'(eb_r) + ACC_W'(ec_r);
  assign dw_ext  = ACC_W'(dw_r);
  assign sp_nxt  = ACC_W'(pa_r) + ACC_W'(pb_r) + ACC_W'(pc_r);
  assign sq_nxt  = (dw_ext <<< 16) + (m_box_r ? $signed(ext_sum) : '0);

  assign total            = sp_r + sq_r;
  assign cull_nxt.valid   = s_valid_r;
  assign cull_nxt.in_view = cull_i.in_view & ~total[ACC_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r       <= '0;
      b_r       <= '0;
      c_r       <= '0;
      d_r       <= '0;
      item_r    <= '0;
      m_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      cull_r    <= '0;
    end else if (adv) begin
      if (load_hit) begin
        a_r <= item_i.vec_x;
        b_r <= item_i.vec_y;
        c_r <= item_i.vec_z;
        d_r <= item_i.vec_w;
      end
      item_r    <= item_i;
      m_valid_r <= item_i.valid && is_test;
      s_valid_r <= m_valid_r;
      cull_r    <= cull_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_box_r <= (item_i.command == CMD_BOX);
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      pc_r    <= pc_nxt;
      ea_r    <= ea_nxt;
      eb_r    <= eb_nxt;
      ec_r    <= ec_nxt;
      dw_r    <= dw_nxt;
      sp_r    <= sp_nxt;
      sq_r    <= sq_nxt;
    end
  end

  assign item_o = item_r;
  assign cull_o = cull_r;

  // the verdict from the upstream cell lines up with this cell's partial sums
  a_cull_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r |-> cull_i.valid)
    else $error("upstream verdict missing for item in partial sum stage");

  // a plane only changes when a matching load passes
  a_plane_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (a_r != $past(a_r) || b_r != $past(b_r) ||
                     c_r != $past(c_r) || d_r != $past(d_r))
    |-> $past(adv && load_hit))
    else $error("plane changed without a load for this cell");

  // a test in the forwarded slot is the one in this cell's multiply stage
  a_test_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r |-> item_r.valid && (item_r.command == CMD_BOX ||
                                   item_r.command == CMD_SPHERE))
    else $error("multiply stage holds a test that is not in the forwarded slot");

endmodule

// ===== design/frustum_containment_test.sv =====
// top level: frustum containment test as a chain of plane cells
//
//   channel   dir  transaction carries
//   in_ch     in   command, plane_index, vec_x..vec_w, ext_x..ext_z
//   out_ch    out  inside_res, one per box or sphere test
//
// one transaction enters per cycle while the chain advances; a result leaves once its test has passed the last cell
// the result path is the cell chain: one cell per plane, three register stages each
// (multiply, partial sums, sign), each cell passing items on from its item register
// synchronous reset clears all planes to zero at once, no sweep
// when the result register is full and not taken the whole chain holds, in_ch.ready drops
module frustum_containment_test
  import fct_pkg::*;
#(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  fct_in_if.sink    in_ch,
  fct_out_if.source out_ch
);

  // transactions and verdicts march down the chain side by side, verdicts behind by the partial sum and sign stages
  fct_item_t item_chain [PLANE_COUNT+1];
  fct_cull_t cull_chain [PLANE_COUNT+1];
  logic      adv;

  // the last cell's verdict register is the result register
  assign adv = !cull_chain[PLANE_COUNT].valid || out_ch.ready;

  assign in_ch.ready = adv;

  assign item_chain[0].valid       = in_ch.valid;
  assign item_chain[0].command     = in_ch.command;
  assign item_chain[0].plane_index = in_ch.plane_index;
  assign item_chain[0].vec_x       = in_ch.vec_x;
  assign item_chain[0].vec_y       = in_ch.vec_y;
  assign item_chain[0].vec_z       = in_ch.vec_z;
  assign item_chain[0].vec_w       = in_ch.vec_w;
  assign item_chain[0].ext_x       = in_ch.ext_x;
  assign item_chain[0].ext_y       = in_ch.ext_y;
  assign item_chain[0].ext_z       = in_ch.ext_z;

  // nothing culled before the first plane
  assign cull_chain[0].valid   = 1'b1;
  assign cull_chain[0].in_view = 1'b1;

  // loads ride the same chain as tests, so each cell sees planes in command order
  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    fct_cell #(
      .CELL_ID (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .item_i (item_chain[g]),
      .item_o (item_chain[g+1]),
      .cull_i (cull_chain[g]),
      .cull_o (cull_chain[g+1])
    );
  end

  assign out_ch.valid      = cull_chain[PLANE_COUNT].valid;
  assign out_ch.inside_res = cull_chain[PLANE_COUNT].in_view;

  // a test leaving the last cell shows up as a result once it has passed the partial sum and sign stages
  a_tail_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_chain[PLANE_COUNT].valid &&
     (item_chain[PLANE_COUNT].command == CMD_BOX ||
      item_chain[PLANE_COUNT].command == CMD_SPHERE)) ##1 adv
    |=> out_ch.valid)
    else $error("test left the chain without a result");

  // input only stalls behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled with no pending result");

endmodule

// ===== tb/tb_frustum_containment_test.sv =====
// self-checking bench for the frustum containment test: random plane sets and object tests
module tb_frustum_containment_test;
  import fct_pkg::*;

  localparam int PLANES = PLANE_COUNT_DEF;

  // handy q16.16 constants
  localparam logic [31:0] FX_ONE       = 32'h0001_0000;
  localparam logic [31:0] FX_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [31:0] FX_HALF      = 32'h0000_8000;
  localparam logic [31:0] FX_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN       = 32'h8000_0000;
  localparam logic [30:0] EXT_MAX      = 31'h7FFF_FFFF;

  // stimulus volume and run bounds
  localparam int TOTAL_ITEMS  = 525;
  localparam int CALM_LEFT    = 50;
  localparam int LONG_HOLD    = 40;
  localparam int DRAIN_CYCLES = PLANES + 12;
  localparam int MAX_PRINTED  = 40;

  // one pending object test: its predicted flag and where it came from
  typedef struct {
    bit         visible;
    logic [1:0] command;
    int         serial;
  } verdict_t;

  logic clk;
  logic rst_n;

  fct_in_if  in_ch ();
  fct_out_if out_ch ();

  frustum_containment_test #(
    .PLANE_COUNT(PLANES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // transactions still to be sent, and flags still to come back
  fct_item_t pending_q[$];
  verdict_t  verdict_q[$];

  // shadow copy of the plane store
  logic signed [31:0] plane_a[PLANES];
  logic signed [31:0] plane_b[PLANES];
  logic signed [31:0] plane_c[PLANES];
  logic signed [31:0] plane_d[PLANES];

  logic in_fire;    // input transaction taken at the last rising edge
  logic calm;       // close to the end: no more idling on either side
  logic hold_long;  // long receiver hold-off in progress
  int   in_gap;
  int   out_gap;

  int err_count;
  int n_items;
  int n_loads;
  int n_box;
  int n_sphere;
  int n_results;
  int n_culled;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  // predicted flag: 1 when no plane culls the object
  // sums are done exactly in 72 bits, so only the sign matters
  function automatic bit predict_visible(input fct_item_t it);
    logic signed [71:0] ca, cb, cc, cd;
    logic signed [71:0] vx, vy, vz, vw;
    logic signed [71:0] ex, ey, ez;
    logic signed [71:0] base, reach;
    bit visible;
    visible = 1'b1;
    vx = $signed(it.vec_x);
    vy = $signed(it.vec_y);
    vz = $signed(it.vec_z);
    vw = $signed(it.vec_w);
    ex = {41'd0, it.ext_x};
    ey = {41'd0, it.ext_y};
    ez = {41'd0, it.ext_z};
    for (int p = 0; p < PLANES; p++) begin
      ca = plane_a[p];
      cb = plane_b[p];
      cc = plane_c[p];
      cd = plane_d[p];
      // plane value of the centre, with d lifted to q32.32
      base = ca * vx + cb * vy + cc * vz + (cd <<< 16);
      if (it.command == CMD_BOX) begin
        // the corner furthest along the normal decides: all eight are
        // negative exactly when that one is
        reach = (ca < 0 ? -ca : ca) * ex + (cb < 0 ? -cb : cb) * ey
              + (cc < 0 ? -cc : cc) * ez;
        if (base + reach < 0) begin
          visible = 1'b0;
        end
      end else begin
        // sphere: culled when the centre lies below minus the radius
        if (base + (vw <<< 16) < 0) begin
          visible = 1'b0;
        end
      end
    end
    return visible;
  endfunction

  function automatic void push_item(input logic [1:0] cmd, input logic [2:0] idx,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic [31:0] w,
                                    input logic [30:0] ex, input logic [30:0] ey,
                                    input logic [30:0] ez);
    fct_item_t it;
    it.valid       = 1'b1;
    it.command     = cmd;
    it.plane_index = idx;
    it.vec_x       = x;
    it.vec_y       = y;
    it.vec_z       = z;
    it.vec_w       = w;
    it.ext_x       = ex;
    it.ext_y       = ey;
    it.ext_z       = ez;
    pending_q.push_back(it);
  endfunction

  // uniform q16.16 value in [-span, span] raw units
  function automatic logic [31:0] rand_fixed(input int unsigned span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - int'(span);
    return v;
  endfunction

  // -------------------------------------------------------------------------
  // input driver: changes at the falling edge, fed from pending_q
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : feed
    fct_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_fire || !in_ch.valid) begin
      if (in_gap > 0) begin
        // idle burst between transactions
        in_gap = in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        it = pending_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.command     <= it.command;
        in_ch.plane_index <= it.plane_index;
        in_ch.vec_x       <= it.vec_x;
        in_ch.vec_y       <= it.vec_y;
        in_ch.vec_z       <= it.vec_z;
        in_ch.vec_w       <= it.vec_w;
        in_ch.ext_x       <= it.ext_x;
        in_ch.ext_y       <= it.ext_y;
        in_ch.ext_z       <= it.ext_z;
        // sometimes follow this transaction with a short gap
        if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 3);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // result ready: random short stalls, a long hold-off once, none at the end
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_long) begin
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 3);
      end
    end
  end

  // long hold-off: the block fills its chain and must drop in_ch.ready
  initial begin
    hold_long = 1'b0;
    while (n_results < 150) @(posedge clk);
    hold_long <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_long <= 1'b0;
  end

  // -------------------------------------------------------------------------
  // monitor: samples both channels at the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    fct_item_t it;
    verdict_t  v;
    if (!rst_n) begin
      in_fire <= 1'b0;
      calm    <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      calm    <= pending_q.size() < CALM_LEFT;

      // accepted input transaction: update the shadow planes or predict
      if (in_ch.valid && in_ch.ready) begin
        it.valid       = 1'b1;
        it.command     = in_ch.command;
        it.plane_index = in_ch.plane_index;
        it.vec_x       = in_ch.vec_x;
        it.vec_y       = in_ch.vec_y;
        it.vec_z       = in_ch.vec_z;
        it.vec_w       = in_ch.vec_w;
        it.ext_x       = in_ch.ext_x;
        it.ext_y       = in_ch.ext_y;
        it.ext_z       = in_ch.ext_z;
        n_items++;
        case (it.command)
          CMD_LOAD: begin
            // out-of-range plane indexes are dropped
            if (it.plane_index < PLANES) begin
              plane_a[it.plane_index] = it.vec_x;
              plane_b[it.plane_index] = it.vec_y;
              plane_c[it.plane_index] = it.vec_z;
              plane_d[it.plane_index] = it.vec_w;
            end
            n_loads++;
          end
          CMD_BOX, CMD_SPHERE: begin
            v.visible = predict_visible(it);
            v.command = it.command;
            v.serial  = n_items;
            verdict_q.push_back(v);
            if (it.command == CMD_BOX) n_box++;
            else n_sphere++;
          end
          default: begin
            // unused command: nothing comes back
          end
        endcase
      end

      // accepted result transaction: compare with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result inside_res=%0b", out_ch.inside_res));
        end else begin
          v = verdict_q.pop_front();
          if (!v.visible) n_culled++;
          if (out_ch.inside_res !== v.visible) begin
            report_mismatch($sformatf("test #%0d (%s): inside_res=%b, predicted %0b",
                                      v.serial, v.command == CMD_BOX ? "box" : "sphere",
                                      out_ch.inside_res, v.visible));
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus, reset and end of run
  // -------------------------------------------------------------------------
  initial begin
    logic [31:0] nrm[3];
    logic [31:0] ctr[3];
    logic [30:0] ext[3];
    logic [31:0] plane_off;
    logic [30:0] side;
    int          shape;
    int          n_tests;

    // every input known from time zero
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_NONE;
    in_ch.plane_index = '0;
    in_ch.vec_x       = '0;
    in_ch.vec_y       = '0;
    in_ch.vec_z       = '0;
    in_ch.vec_w       = '0;
    in_ch.ext_x       = '0;
    in_ch.ext_y       = '0;
    in_ch.ext_z       = '0;
    out_ch.ready      = 1'b0;
    in_gap            = 0;
    out_gap           = 0;
    err_count         = 0;
    n_items           = 0;
    n_loads           = 0;
    n_box             = 0;
    n_sphere          = 0;
    n_results         = 0;
    n_culled          = 0;
    for (int p = 0; p < PLANES; p++) begin
      plane_a[p] = '0;
      plane_b[p] = '0;
      plane_c[p] = '0;
      plane_d[p] = '0;
    end

    // directed part
    // planes all zero after reset: value zero is not negative, so a point is inside
    push_item(CMD_BOX, 3'd0, '0, '0, '0, '0, '0, '0, '0);
    // zero planes and a negative radius: the sphere is culled
    push_item(CMD_SPHERE, 3'd0, FX_ONE, FX_ONE, FX_ONE, FX_MINUS_ONE, '0, '0, '0);
    // unused command returns nothing
    push_item(CMD_NONE, 3'd7, $urandom, $urandom, $urandom, $urandom,
              31'($urandom), 31'($urandom), 31'($urandom));
    // loads to indexes past the last plane would cull everything if taken
    push_item(CMD_LOAD, 3'd6, '0, '0, '0, FX_MIN, '0, '0, '0);
    push_item(CMD_LOAD, 3'd7, '0, '0, '0, FX_MIN, '0, '0, '0);
    push_item(CMD_BOX, 3'd5, '0, '0, '0, '0, EXT_MAX, EXT_MAX, EXT_MAX);
    // plane 0: x >= 0
    push_item(CMD_LOAD, 3'd0, FX_ONE, '0, '0, '0, '0, '0, '0);
    push_item(CMD_BOX, 3'd0, FX_MINUS_ONE, '0, '0, '0, '0, '0, '0);
    push_item(CMD_BOX, 3'd0, '0, FX_MINUS_ONE, '0, '0, '0, '0, '0);
    // box touching the plane with one face, then just short of it
    push_item(CMD_BOX, 3'd0, 32'hFFFE_0000, '0, '0, '0, 31'h2_0000, 31'h1234, '0);
    push_item(CMD_BOX, 3'd0, 32'hFFFE_0000, '0, '0, '0, 31'h1_FFFF, 31'h1234, '0);
    // cube well outside
    push_item(CMD_BOX, 3'd0, 32'hFFFD_0000, '0, '0, '0, 31'h1_0000, 31'h1_0000, 31'h1_0000);
    // sphere exactly touching, then too small, then a negative radius
    push_item(CMD_SPHERE, 3'd0, FX_MINUS_ONE, '0, '0, FX_ONE, '0, '0, '0);
    push_item(CMD_SPHERE, 3'd0, FX_MINUS_ONE, '0, '0, FX_HALF, '0, '0, '0);
    push_item(CMD_SPHERE, 3'd0, FX_HALF, '0, '0, FX_MINUS_ONE, '0, '0, '0);
    // extreme coefficients and operands
    push_item(CMD_LOAD, 3'd5, FX_MIN, FX_MAX, FX_MIN, FX_MAX, '0, '0, '0);
    push_item(CMD_BOX, 3'd1, FX_MAX, FX_MIN, FX_MAX, '0, EXT_MAX, EXT_MAX, EXT_MAX);
    push_item(CMD_BOX, 3'd2, FX_MIN, FX_MAX, FX_MIN, '0, '0, '0, '0);
    push_item(CMD_SPHERE, 3'd3, FX_MIN, FX_MIN, FX_MAX, FX_MIN, '0, '0, '0);
    push_item(CMD_SPHERE, 3'd4, FX_MAX, FX_MAX, FX_MIN, FX_MAX, '0, '0, '0);
    // smallest negative coefficient culls a point one lsb away
    push_item(CMD_LOAD, 3'd3, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0);
    push_item(CMD_BOX, 3'd0, 32'h0000_0001, '0, '0, '0, '0, '0, '0);
    push_item(CMD_BOX, 3'd0, '0, '0, '0, '0, '0, '0, '0);
    push_item(CMD_NONE, 3'd7, '1, '1, '1, '1, '1, '1, '1);

    // random part: mostly well-formed frames (six planes, then a run of
    // objects near the bounds), the rest full-range noise
    while (pending_q.size() < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        // axis-aligned box frustum, sometimes tilted a little
        for (int p = 0; p < PLANES; p++) begin
          for (int k = 0; k < 3; k++) begin
            nrm[k] = ($urandom_range(0, 9) < 3) ? rand_fixed(20000) : '0;
          end
          nrm[(p / 2) % 3] = (p % 2) ? FX_MINUS_ONE : FX_ONE;
          plane_off = ($urandom_range(10, 100) << 16) | $urandom_range(0, 65535);
          push_item(CMD_LOAD, p[2:0], nrm[0], nrm[1], nrm[2], plane_off,
                    31'($urandom), 31'($urandom), 31'($urandom));
        end
        n_tests = $urandom_range(15, 35);
        for (int t = 0; t < n_tests; t++) begin
          if ($urandom_range(0, 9) == 0) begin
            // ignored traffic mixed in
            push_item($urandom_range(0, 1) ? CMD_NONE : CMD_LOAD,
                      3'(6 + $urandom_range(0, 1)), $urandom, $urandom, $urandom,
                      $urandom, 31'($urandom), 31'($urandom), 31'($urandom));
          end else begin
            for (int k = 0; k < 3; k++) begin
              ctr[k] = rand_fixed(120 << 16);
              ext[k] = 31'($urandom_range(0, 30 << 16));
            end
            shape = $urandom_range(0, 3);
            if (shape == 0) begin
              // point
              ext[0] = '0;
              ext[1] = '0;
              ext[2] = '0;
            end else if (shape == 1) begin
              // cube
              side = ext[0];
              ext[1] = side;
              ext[2] = side;
            end
            if ($urandom_range(0, 1)) begin
              push_item(CMD_BOX, 3'($urandom_range(0, 7)), ctr[0], ctr[1], ctr[2], $urandom,
                        ext[0], ext[1], ext[2]);
            end else begin
              push_item(CMD_SPHERE, 3'($urandom_range(0, 7)), ctr[0], ctr[1], ctr[2],
                        rand_fixed(30 << 16) + (25 << 16),
                        31'($urandom), 31'($urandom), 31'($urandom));
            end
          end
        end
      end else begin
        // full-range noise, random plane loads included
        n_tests = $urandom_range(5, 15);
        for (int t = 0; t < n_tests; t++) begin
          push_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom, $urandom,
                    $urandom, $urandom, 31'($urandom >> 1), 31'($urandom >> 1),
                    31'($urandom >> 1));
        end
      end
    end

    // synchronous reset, held and then released at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all stimulus taken, then all flags back, then let the chain drain
    while (pending_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never came", verdict_q.size()));
    end

    $display("run covered %0d transactions: %0d plane loads, %0d box tests, %0d sphere tests",
             n_items, n_loads, n_box, n_sphere);
    $display("checked %0d results, %0d culled, %0d mismatches",
             n_results, n_culled, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard limit on the run, far above the slowest legal run
  initial begin
    #600000;
    $display("timeout: %0d results still outstanding", verdict_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
